@@ sv/haversine_distance_defines.svh @@
// Assertion macros shared by the haversine distance RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HAV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HAV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hav_pkg.sv @@
// Types, constants and constant tables for the haversine distance pipeline.
// Depends on nothing; imported by the cells, the top level and the testbench.
package hav_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STAGES   = 31;
    localparam int CW            = 34;
    localparam int ZW            = 33;
    localparam int SQW           = 62;
    localparam int RADIUS_W      = 23;
    localparam int DIST_W        = 33;
    // input register, wrap, scale multiply, angle round, then the back end
    localparam int LAT = 4 + CORDIC_STAGES + 5 + SQRT_STAGES + CORDIC_STAGES + 2;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG2RAD_Q36 = (PI_Q60 + 64'd1509949440) / 64'd3019898880;
    localparam logic [30:0] DEG2RAD     = DEG2RAD_Q36[30:0];

    localparam logic signed [33:0] HALF_TURN    = 34'sd3019898880;
    localparam logic signed [33:0] FULL_TURN    = 34'sd6039797760;
    localparam logic [31:0]        HALF_TURN_U  = 32'd3019898880;
    localparam logic [31:0]        QUARTER_U    = 32'd1509949440;

    localparam logic signed [CW-1:0] GAIN_INV = CW'(32'h26DD3B6A);
    localparam logic signed [CW-1:0] ONE_Q30  = CW'(1073741824);
    localparam logic [60:0]          ONE_Q60  = 61'(1) << 60;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 23'd6378137;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] res;
    } t_sqrt;

    // atan(2^-i) in Q30, rounded
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:  r = ZW'(32'h3243F6A9);
            1:  r = ZW'(32'h1DAC6705);
            2:  r = ZW'(32'h0FADBAFD);
            3:  r = ZW'(32'h07F56EA7);
            4:  r = ZW'(32'h03FEAB77);
            5:  r = ZW'(32'h01FFD55C);
            6:  r = ZW'(32'h00FFFAAB);
            7:  r = ZW'(32'h007FFF55);
            8:  r = ZW'(32'h003FFFEB);
            9:  r = ZW'(32'h001FFFFD);
            10: r = ZW'(32'h00100000);
            default: begin
                if (i <= 30) r = ZW'(64'd1 << (30 - i));
                else if (i == 31) r = ZW'(1);
                else r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) r = 32'(ONE_Q30);
        else if (v < -ONE_Q30) r = 32'(-ONE_Q30);
        else r = 32'(v);
        return r;
    endfunction

endpackage

@@ sv/hav_in_if.sv @@
// Input channel: one pair of points per beat, valid/ready handshake.
// Stand-alone; no package needed; payload widths are fixed.
interface hav_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  lat_a;
    logic signed [32:0]  lon_a;
    logic signed [31:0]  lat_b;
    logic signed [32:0]  lon_b;

    modport source (output valid, output lat_a, output lon_a, output lat_b,
                    output lon_b, input ready);
    modport sink   (input valid, input lat_a, input lon_a, input lat_b,
                    input lon_b, output ready);
endinterface

@@ sv/hav_out_if.sv @@
// Output channel: one distance per beat, valid/ready handshake.
// Stand-alone; no package needed.
interface hav_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

@@ sv/hav_cordic_cell.sv @@
// One CORDIC micro-rotation stage, rotation or vectoring mode.
// Depends on hav_pkg (t_cordic, widths).
module hav_cordic_cell import hav_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_vector,
    input  logic [5:0]           i_shift,
    input  logic signed [ZW-1:0] i_atan,
    input  t_cordic              i_d,
    output t_cordic              o_d
);

    logic signed [CW-1:0] w_x, w_y, w_dx, w_dy;
    logic signed [ZW-1:0] w_z;
    logic                 w_dir;
    t_cordic              n_d, r_d;

    assign w_x  = i_d.x;
    assign w_y  = i_d.y;
    assign w_z  = i_d.z;
    assign w_dx = w_y >>> i_shift;
    assign w_dy = w_x >>> i_shift;
    // rotation steers on the residual angle, vectoring drives y to zero
    assign w_dir = i_vector ? w_y[CW-1] : ~w_z[ZW-1];

    always_comb begin
        if (w_dir) begin
            n_d.x = w_x - w_dx;
            n_d.y = w_y + w_dy;
            n_d.z = w_z - i_atan;
        end else begin
            n_d.x = w_x + w_dx;
            n_d.y = w_y - w_dy;
            n_d.z = w_z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

@@ sv/hav_sqrt_cell.sv @@
// One digit step of a restoring integer square root.
// Depends on hav_pkg (t_sqrt, SQW).
module hav_sqrt_cell import hav_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [SQW-1:0] i_bit,
    input  t_sqrt          i_d,
    output t_sqrt          o_d
);

    logic [SQW-1:0] w_sum;
    t_sqrt          n_d, r_d;

    assign w_sum = i_d.res + i_bit;

    always_comb begin
        if (i_d.rem >= w_sum) begin
            n_d.rem = i_d.rem - w_sum;
            n_d.res = (i_d.res >> 1) + i_bit;
        end else begin
            n_d.rem = i_d.rem;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

@@ sv/haversine_distance.sv @@
// Top level: haversine great-circle distance pipeline.
// Depends on hav_pkg, hav_in_if, hav_out_if, hav_cordic_cell, hav_sqrt_cell
// and the assertion macros in haversine_distance_defines.svh.
//
// Usage:
//   i_pt carries one beat per point pair: lat_a, lat_b in signed Q8.24 and
//   lon_a, lon_b in signed Q9.24 degrees. o_dist returns one beat per pair,
//   distance in meters as unsigned Q25.8, saturated at all ones.
//   i_cfg_we/i_cfg_wdata write the sphere radius in whole meters; write it
//   only while no pair is in flight.
//   Throughput is one pair per cycle while the skid register is empty. A
//   result passes through four front-end stages, 24 CORDIC cells for the
//   sines and cosines, five product stages, 31 square-root cells, 24 CORDIC
//   cells for the angle, two scaling stages and the output register.
//   When the receiver stalls, one extra beat lands in a skid register; i_pt
//   ready then drops and the whole pipeline holds until the skid drains.
//   Reset (synchronous, active low) empties the pipeline and sets the
//   radius to 6378137 m.
`include "haversine_distance_defines.svh"

module haversine_distance import hav_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hav_in_if.sink              i_pt,
    hav_out_if.source           o_dist,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata
);

    logic                w_en, w_acc;
    logic [RADIUS_W-1:0] r_radius;
    logic [LAT-1:0]      r_vld;

    // front end
    logic signed [31:0] r_la, r_lb;
    logic signed [32:0] r_dlat;
    logic signed [33:0] r_dlon;
    logic signed [33:0] w_dl, w_dn, w_dlw, w_dnw;
    logic [31:0]        w_ma32, w_mb32, n_hm_lat, n_hm_lon;
    logic [30:0]        n_m_a, n_m_b;
    logic [1:0]         n_ng;
    logic [31:0]        r_hm_lat, r_hm_lon;
    logic [30:0]        r_m_a, r_m_b;
    logic [1:0]         r_ng;
    logic [1:0]         r_ngd [0:CORDIC_STAGES+1];
    logic [62:0]        r_pr [4];
    logic signed [ZW-1:0] r_ang [4];

    t_cordic w_rot [4][CORDIC_STAGES+1];
    t_cordic w_vec [CORDIC_STAGES+1];
    t_sqrt   w_sa [SQRT_STAGES+1];
    t_sqrt   w_sb [SQRT_STAGES+1];

    // back end
    logic signed [31:0] w_s1, w_s2, w_c1, w_c2, w_p30, w_t;
    logic signed [31:0] r_s1, r_s2, r_c1, r_c2, r_s2b, r_s2c;
    logic signed [63:0] r_pc, r_tp, r_ts, w_a;
    logic signed [61:0] r_sq, r_sq2, r_sq3;
    logic [60:0]        n_a, r_a, r_b;
    logic signed [ZW-1:0] w_th;
    logic [31:0]        w_two_th;
    logic [54:0]        r_prod;
    logic [55:0]        w_rd;
    logic [33:0]        w_q;
    logic [DIST_W-1:0]  r_dist;

    // output register and skid
    logic              r_out_valid, r_sk_valid;
    logic [DIST_W-1:0] r_out_dist, r_sk_dist;

    assign w_en       = ~r_sk_valid;
    assign i_pt.ready = w_en;
    assign w_acc      = i_pt.valid & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // wrap differences into one turn, fold latitudes into the first quadrant
    assign w_dl  = 34'(r_dlat);
    assign w_dn  = r_dlon;
    assign w_dlw = (w_dl >= HALF_TURN) ? w_dl - FULL_TURN :
                   (w_dl < -HALF_TURN) ? w_dl + FULL_TURN : w_dl;
    assign w_dnw = (w_dn >= HALF_TURN) ? w_dn - FULL_TURN :
                   (w_dn < -HALF_TURN) ? w_dn + FULL_TURN : w_dn;
    assign n_hm_lat = w_dlw[33] ? 32'(-w_dlw) : 32'(w_dlw);
    assign n_hm_lon = w_dnw[33] ? 32'(-w_dnw) : 32'(w_dnw);
    assign w_ma32 = r_la[31] ? 32'(-34'(r_la)) : 32'(r_la);
    assign w_mb32 = r_lb[31] ? 32'(-34'(r_lb)) : 32'(r_lb);

    always_comb begin
        n_ng = 2'b00;
        n_m_a = 31'(w_ma32);
        n_m_b = 31'(w_mb32);
        if (w_ma32 > QUARTER_U) begin
            n_m_a   = 31'(HALF_TURN_U - w_ma32);
            n_ng[0] = 1'b1;
        end
        if (w_mb32 > QUARTER_U) begin
            n_m_b   = 31'(HALF_TURN_U - w_mb32);
            n_ng[1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la     <= i_pt.lat_a;
            r_lb     <= i_pt.lat_b;
            r_dlat   <= 33'(i_pt.lat_b) - 33'(i_pt.lat_a);
            r_dlon   <= 34'(i_pt.lon_b) - 34'(i_pt.lon_a);
            r_hm_lat <= n_hm_lat;
            r_hm_lon <= n_hm_lon;
            r_m_a    <= n_m_a;
            r_m_b    <= n_m_b;
            r_ng     <= n_ng;
            r_pr[0]  <= r_hm_lat * DEG2RAD;
            r_pr[1]  <= r_hm_lon * DEG2RAD;
            r_pr[2]  <= r_m_a * DEG2RAD;
            r_pr[3]  <= r_m_b * DEG2RAD;
            // half angles round at bit 31, latitudes at bit 30
            r_ang[0] <= ZW'((r_pr[0] + (63'd1 << 30)) >> 31);
            r_ang[1] <= ZW'((r_pr[1] + (63'd1 << 30)) >> 31);
            r_ang[2] <= ZW'((r_pr[2] + (63'd1 << 29)) >> 30);
            r_ang[3] <= ZW'((r_pr[3] + (63'd1 << 29)) >> 30);
            r_ngd[0] <= r_ng;
            for (int k = 1; k < CORDIC_STAGES + 2; k++) r_ngd[k] <= r_ngd[k-1];
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_rot
        assign w_rot[c][0] = '{x: GAIN_INV, y: '0, z: r_ang[c]};
        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
            hav_cordic_cell u_cell (
                .i_clk    (i_clk),
                .i_en     (w_en),
                .i_vector (1'b0),
                .i_shift  (6'(k)),
                .i_atan   (atan_q30(k)),
                .i_d      (w_rot[c][k]),
                .o_d      (w_rot[c][k+1])
            );
        end
    end

    assign w_s1 = clamp_unit(w_rot[0][CORDIC_STAGES].y);
    assign w_s2 = clamp_unit(w_rot[1][CORDIC_STAGES].y);
    assign w_c1 = r_ngd[CORDIC_STAGES+1][0] ? -clamp_unit(w_rot[2][CORDIC_STAGES].x)
                                            : clamp_unit(w_rot[2][CORDIC_STAGES].x);
    assign w_c2 = r_ngd[CORDIC_STAGES+1][1] ? -clamp_unit(w_rot[3][CORDIC_STAGES].x)
                                            : clamp_unit(w_rot[3][CORDIC_STAGES].x);

    assign w_p30 = 32'((r_pc + 64'sd536870912) >>> 30);
    assign w_t   = 32'(r_tp >>> 30);
    assign w_a   = 64'(r_sq3) + r_ts;

    // clamp a into [0, 1] before 1 - a is taken
    always_comb begin
        if (w_a[63]) n_a = '0;
        else if (w_a[62:0] > 63'(ONE_Q60)) n_a = ONE_Q60;
        else n_a = 61'(w_a);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= w_s1;
            r_s2  <= w_s2;
            r_c1  <= w_c1;
            r_c2  <= w_c2;
            r_pc  <= r_c1 * r_c2;
            r_sq  <= r_s1 * r_s1;
            r_s2b <= r_s2;
            r_tp  <= w_p30 * r_s2b;
            r_sq2 <= r_sq;
            r_s2c <= r_s2b;
            r_ts  <= w_t * r_s2c;
            r_sq3 <= r_sq2;
            r_a   <= n_a;
            r_b   <= ONE_Q60 - n_a;
        end
    end

    assign w_sa[0] = '{rem: SQW'(r_a), res: '0};
    assign w_sb[0] = '{rem: SQW'(r_b), res: '0};

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        hav_sqrt_cell u_sa (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_bit (SQW'(1) << (2 * (SQRT_STAGES - 1 - j))),
            .i_d   (w_sa[j]),
            .o_d   (w_sa[j+1])
        );
        hav_sqrt_cell u_sb (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_bit (SQW'(1) << (2 * (SQRT_STAGES - 1 - j))),
            .i_d   (w_sb[j]),
            .o_d   (w_sb[j+1])
        );
    end

    // angle of (sqrt(1 - a), sqrt(a))
    assign w_vec[0] = '{x: CW'(w_sb[SQRT_STAGES].res), y: CW'(w_sa[SQRT_STAGES].res),
                        z: '0};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        hav_cordic_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_vector (1'b1),
            .i_shift  (6'(k)),
            .i_atan   (atan_q30(k)),
            .i_d      (w_vec[k]),
            .o_d      (w_vec[k+1])
        );
    end

    assign w_th     = w_vec[CORDIC_STAGES].z;
    assign w_two_th = w_th[ZW-1] ? '0 : {w_th[30:0], 1'b0};
    assign w_rd     = 56'(r_prod) + (56'd1 << 21);
    assign w_q      = 34'(w_rd >> 22);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= r_radius * w_two_th;
            r_dist <= w_q[33] ? '1 : w_q[DIST_W-1:0];
        end
    end

    // output register with one skid beat behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || o_dist.ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= r_vld[LAT-1];
            end
        end else if (r_vld[LAT-1] && w_en) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_dist.ready) begin
            r_out_dist <= r_sk_valid ? r_sk_dist : r_dist;
        end else if (w_en) begin
            r_sk_dist <= r_dist;
        end
    end

    assign o_dist.valid    = r_out_valid;
    assign o_dist.distance = r_out_dist;

    `HAV_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_sk_valid, r_out_valid,
        "skid holds a beat while the output register is empty")
    `HAV_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        r_out_valid && !o_dist.ready && r_vld[LAT-1] && !r_sk_valid, r_sk_valid,
        "stalled result was not caught by the skid register")
    `HAV_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n,
        r_out_valid && o_dist.ready && !r_sk_valid && !r_vld[LAT-1], !r_out_valid,
        "output stayed valid after its beat was taken with nothing behind it")

endmodule

@@ verif/tb.sv @@
// Testbench for haversine_distance: random and edge-case point pairs, with distances
// predicted in fixed point and compared beat by beat.
// Depends on hav_pkg, hav_in_if, hav_out_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import hav_pkg::*;

    localparam int         STAGES    = CORDIC_STAGES;
    localparam longint     LIMIT     = 600000;
    localparam longint     HALF_DEG  = 64'sd3019898880;
    localparam longint     FULL_DEG  = 64'sd6039797760;
    localparam longint     QUART_DEG = 64'sd1509949440;
    localparam longint unsigned PI60 = 64'h3243F6A8885A308D;
    localparam longint unsigned RAD_K = (PI60 + 64'd1509949440) / 64'd3019898880;
    localparam longint     UNIT30    = 64'sd1073741824;
    localparam longint unsigned UNIT60 = 64'd1 << 60;
    localparam longint unsigned SAT_M = 64'd8589934591;

    typedef struct {
        logic signed [31:0] lat_a;
        logic signed [32:0] lon_a;
        logic signed [31:0] lat_b;
        logic signed [32:0] lon_b;
    } t_pair;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_wdata;

    hav_in_if  pt_if ();
    hav_out_if dist_if ();

    haversine_distance dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .o_dist     (dist_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_pair          pair_q[$];
    logic [32:0]    dist_exp_q[$];
    longint unsigned radius_m = 6378137;
    int             src_idle = 8;
    int             snk_idle = 85;
    int             errors = 0;
    longint         cycles = 0;

    function automatic longint arctan_q30(int i);
        longint unsigned acc, term;
        longint unsigned pw;
        acc = 0;
        if (i == 0) return longint'((PI60 + (64'd1 << 31)) >> 32);
        for (int k = 0; k < 64; k++) begin
            pw = longint'(i) * (2 * k + 1);
            if (pw > 62) break;
            term = (64'd1 << (62 - pw)) / longint'(2 * k + 1);
            if (k % 2) acc = acc - term;
            else acc = acc + term;
        end
        return longint'((acc + (64'd1 << 31)) >> 32);
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > UNIT30) return UNIT30;
        if (v < -UNIT30) return -UNIT30;
        return v;
    endfunction

    function automatic void rotate_cs(longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy, t;
        x = 64'sh26DD3B6A;
        y = 0;
        z = ang;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = arctan_q30(i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - t;
            end else begin
                x = x + dx; y = y - dy; z = z + t;
            end
        end
        c = clip_unit(x);
        s = clip_unit(y);
    endfunction

    function automatic longint vector_ang(longint x, longint y);
        longint z, dx, dy, t;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = arctan_q30(i);
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + t;
            end else begin
                x = x - dx; y = y + dy; z = z - t;
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint wrap_turn(longint d);
        longint m;
        m = (d + HALF_DEG) % FULL_DEG;
        if (m < 0) m = m + FULL_DEG;
        return m - HALF_DEG;
    endfunction

    function automatic longint half_diff_sine(longint d);
        longint r, c, s, h;
        longint unsigned mag;
        r   = wrap_turn(d);
        mag = (r < 0) ? -r : r;
        h   = longint'((mag * RAD_K + (64'd1 << 30)) >> 31);
        rotate_cs(h, c, s);
        return s;
    endfunction

    function automatic longint lat_cos(longint lat);
        longint r, m, c, s, ang;
        bit neg;
        r   = wrap_turn(lat);
        m   = (r < 0) ? -r : r;
        neg = 0;
        if (m > QUART_DEG) begin
            m = HALF_DEG - m;
            neg = 1;
        end
        ang = longint'((longint'(unsigned'(m)) * RAD_K + (64'd1 << 29)) >> 30);
        rotate_cs(ang, c, s);
        return neg ? -c : c;
    endfunction

    function automatic logic [32:0] great_circle(t_pair p, longint unsigned rad);
        longint la, oa, lb, ob, s1, s2, c1, c2, p30, t, a, theta;
        longint unsigned au, u, v, d;
        la = longint'(p.lat_a);
        oa = longint'(p.lon_a);
        lb = longint'(p.lat_b);
        ob = longint'(p.lon_b);
        s1 = half_diff_sine(lb - la);
        s2 = half_diff_sine(ob - oa);
        c1 = lat_cos(la);
        c2 = lat_cos(lb);
        p30 = (c1 * c2 + (64'sd1 << 29)) >>> 30;
        t   = (p30 * s2) >>> 30;
        a   = s1 * s1 + t * s2;
        if (a < 0) a = 0;
        au = a;
        if (au > UNIT60) au = UNIT60;
        u = int_sqrt(au);
        v = int_sqrt(UNIT60 - au);
        theta = vector_ang(longint'(v), longint'(u));
        if (theta < 0) theta = 0;
        d = (rad * (2 * longint'(unsigned'(theta))) + (64'd1 << 21)) >> 22;
        if (d > SAT_M) d = SAT_M;
        return d[32:0];
    endfunction

    function automatic t_pair mk_pair(longint la, longint oa, longint lb, longint ob);
        t_pair p;
        p.lat_a = la[31:0];
        p.lon_a = oa[32:0];
        p.lat_b = lb[31:0];
        p.lon_b = ob[32:0];
        return p;
    endfunction

    function automatic void queue_pair(t_pair p);
        pair_q = {pair_q, p};
    endfunction

    function automatic longint rnd_lat();
        return longint'($urandom_range(0, 32'd3019898880)) - QUART_DEG;
    endfunction

    function automatic longint rnd_lon();
        longint v;
        v = longint'($urandom_range(0, 32'd3019898880));
        return $urandom_range(1) ? v : -v;
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        int    kind;
        longint la, oa;
        kind = $urandom_range(99);
        if (kind < 70) begin
            p = mk_pair(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon());
        end else if (kind < 85) begin
            // near neighbours, small deltas
            la = rnd_lat();
            oa = rnd_lon();
            p = mk_pair(la, oa, la + $signed($urandom_range(0, 2000000)) - 1000000,
                        oa + $signed($urandom_range(0, 2000000)) - 1000000);
        end else begin
            // raw bit patterns, outside the nominal ranges too
            p.lat_a = $urandom;
            p.lon_a = {1'($urandom_range(1)), $urandom};
            p.lat_b = $urandom;
            p.lon_b = {1'($urandom_range(1)), $urandom};
        end
        return p;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: predict on each accepted beat, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                dist_exp_q = {dist_exp_q, great_circle(
                    mk_pair(pt_if.lat_a, pt_if.lon_a, pt_if.lat_b, pt_if.lon_b), radius_m)};
            end
            if (!pt_if.valid || pt_if.ready) begin
                if (pair_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                    t_pair p;
                    p = pair_q.pop_front();
                    pt_if.valid <= 1'b1;
                    pt_if.lat_a <= p.lat_a;
                    pt_if.lon_a <= p.lon_a;
                    pt_if.lat_b <= p.lat_b;
                    pt_if.lon_b <= p.lon_b;
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dist_if.ready <= 1'b0;
        end else begin
            if (dist_if.valid && dist_if.ready) begin
                if (dist_exp_q.size() == 0) begin
                    $display("%0t: unexpected distance beat, actual %0d", $time,
                             dist_if.distance);
                    errors++;
                end else begin
                    logic [32:0] want;
                    want = dist_exp_q.pop_front();
                    if (want !== dist_if.distance) begin
                        $display("%0t: distance mismatch, expected %0d actual %0d",
                                 $time, want, dist_if.distance);
                        errors++;
                    end
                end
            end
            dist_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // sample on the falling edge, once the driver's updates have settled
    task automatic drain();
        while (pair_q.size() > 0 || pt_if.valid || dist_exp_q.size() > 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_radius(longint unsigned r);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r[RADIUS_W-1:0];
        radius_m = r & 64'h7FFFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    longint unsigned radii[7];

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        pt_if.valid  = 1'b0;
        pt_if.lat_a  = '0;
        pt_if.lon_a  = '0;
        pt_if.lat_b  = '0;
        pt_if.lon_b  = '0;
        dist_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners with the reset radius
        queue_pair(mk_pair(0, 0, 0, 0));
        queue_pair(mk_pair(QUART_DEG, 123456, QUART_DEG, 123456));
        queue_pair(mk_pair(QUART_DEG, 0, -QUART_DEG, 0));
        queue_pair(mk_pair(0, -HALF_DEG, 0, HALF_DEG));
        queue_pair(mk_pair(0, 0, 0, HALF_DEG));
        queue_pair(mk_pair(0, 0, 0, -HALF_DEG));
        queue_pair(mk_pair(0, 0, 0, QUART_DEG));
        queue_pair(mk_pair(-QUART_DEG, -HALF_DEG, QUART_DEG, HALF_DEG));
        queue_pair(mk_pair(64'sh7FFFFFFF, 64'shFFFFFFFF, -64'sh80000000,
                           -64'sh100000000));
        queue_pair(mk_pair(-64'sh80000000, -64'sh100000000, 64'sh7FFFFFFF,
                           64'shFFFFFFFF));
        queue_pair(mk_pair(-1, -1, -1, -1));
        queue_pair(mk_pair(0, 0, 1, 1));
        queue_pair(mk_pair(QUART_DEG, 0, QUART_DEG, HALF_DEG));
        queue_pair(mk_pair(QUART_DEG - 1, 0, -QUART_DEG + 1, HALF_DEG - 1));
        queue_pair(mk_pair(64'sd754974720, 64'sd1509949440, -64'sd754974720,
                           -64'sd1509949440));
        queue_pair(mk_pair(0, 64'sd3019898879, 0, -64'sd3019898880));
        drain();

        radii[0] = 1;
        radii[1] = 8388607;
        radii[2] = 0;
        radii[3] = $urandom_range(1, 8388607);
        radii[4] = $urandom_range(1, 8388607);
        radii[5] = 6378137;
        radii[6] = 8388607;
        for (int ph = 0; ph < 7; ph++) begin
            write_radius(radii[ph]);
            if (ph < 2) begin
                src_idle = 8; snk_idle = 85;
            end else if (ph < 4) begin
                src_idle = 85; snk_idle = 8;
            end else begin
                src_idle = 0; snk_idle = 0;
            end
            for (int n = 0; n < 290; n++) queue_pair(rnd_pair());
            drain();
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/hav_pkg.sv
sv/hav_in_if.sv
sv/hav_out_if.sv
sv/hav_cordic_cell.sv
sv/hav_sqrt_cell.sv
sv/haversine_distance.sv
verif/tb.sv
